// ===== rtl/core/lpm_pkg.sv =====
// shared constants, types and helpers for the longest prefix match table
`default_nettype none

package lpm_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int OP_W   = 2;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int AS_W   = 32;
    localparam int ST_W   = 2;

    // longest legal prefix length
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    // one stored table entry
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic [AS_W-1:0]   as_num;
    } t_entry;

    // mask of the top len bits, len never above the address width
    function automatic logic [ADDR_W-1:0] top_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] ones;
        ones     = '1;
        top_mask = ~(ones >> len);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/longest_prefix_match_table_core.sv =====
// longest prefix match table: entry memory, scan sequencer and output register
//
// Usage: transactions enter on i_valid / o_stall with the fields operation,
// address, prefix_length and as_number, and every transaction returns one
// result on o_valid / i_stall. A transaction is taken when valid is high and
// stall is low. Clear empties the table (count only), insert appends one
// entry (status full when the table already holds TABLE_DEPTH entries),
// lookup scans the stored entries in insertion order and returns the
// strictly longest matching prefix of nonzero length, the earliest one on a tie.
// Clear, insert and the unused code go from acceptance through the emit
// state to the output register. A lookup reads one entry a cycle from the
// entry memory, then passes through the emit state to the output register.
// One transaction is worked on at a time; a new one is taken as soon as the
// previous result has moved into the output register, even while that
// result still waits. When the receiver stalls, the result holds in the
// output register and the next finished result waits behind it.
// Reset empties the table and drops any work in flight; entry contents
// are not cleared since only entries below the count are read.
`default_nettype none

module longest_prefix_match_table_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input channel
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [lpm_pkg::OP_W-1:0]     i_operation,
    input  wire logic [lpm_pkg::ADDR_W-1:0]   i_address,
    input  wire logic [lpm_pkg::LEN_W-1:0]    i_prefix_length,
    input  wire logic [lpm_pkg::AS_W-1:0]     i_as_number,
    // result channel
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [lpm_pkg::ST_W-1:0]          o_status,
    output logic [lpm_pkg::ADDR_W-1:0]        o_matched_prefix,
    output logic [lpm_pkg::LEN_W-1:0]         o_matched_length,
    output logic [lpm_pkg::AS_W-1:0]          o_matched_as
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [lpm_pkg::CNT_W-1:0]    r_count;
    logic [lpm_pkg::CNT_W-1:0]    r_scan_idx;
    logic                         r_rd_pend;
    logic [lpm_pkg::ADDR_W-1:0]   r_query;

    // pending result
    logic [lpm_pkg::ST_W-1:0]     r_res_status;
    logic [lpm_pkg::ADDR_W-1:0]   r_res_prefix;
    logic [lpm_pkg::LEN_W-1:0]    r_res_length;
    logic [lpm_pkg::AS_W-1:0]     r_res_as;

    // output register
    logic                         r_out_valid;
    logic [lpm_pkg::ST_W-1:0]     r_out_status;
    logic [lpm_pkg::ADDR_W-1:0]   r_out_prefix;
    logic [lpm_pkg::LEN_W-1:0]    r_out_length;
    logic [lpm_pkg::AS_W-1:0]     r_out_as;

    // entry memory
    lpm_pkg::t_entry              r_mem [lpm_pkg::TABLE_DEPTH];
    lpm_pkg::t_entry              r_rd_data;

    logic                         w_accept;
    logic                         w_full;
    logic                         w_issue;
    logic                         w_hit;
    logic                         w_out_free;
    logic [lpm_pkg::LEN_W-1:0]    w_ins_len;
    lpm_pkg::t_entry              w_wr_entry;

    assign w_accept   = i_valid && !o_stall;
    assign w_full     = (r_count == lpm_pkg::CNT_W'(lpm_pkg::TABLE_DEPTH));
    assign w_issue    = (r_state == S_SCAN) && (r_scan_idx < r_count);
    assign w_out_free = !r_out_valid || !i_stall;

    // saturate the inserted length
    assign w_ins_len = (i_prefix_length > lpm_pkg::MAX_LEN) ? lpm_pkg::MAX_LEN
                                                            : i_prefix_length;
    assign w_wr_entry = '{prefix: i_address, length: w_ins_len, as_num: i_as_number};

    // match of the entry read in the previous cycle against the best so far
    assign w_hit = r_rd_pend && (r_rd_data.length > r_res_length) &&
                   (((r_query ^ r_rd_data.prefix) &
                     lpm_pkg::top_mask(r_rd_data.length)) == '0);

    // memory write on insert and registered read for the scan
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_operation == lpm_pkg::OP_INSERT) && !w_full) begin
            r_mem[r_count[lpm_pkg::IDX_W-1:0]] <= w_wr_entry;
        end
        r_rd_data <= r_mem[r_scan_idx[lpm_pkg::IDX_W-1:0]];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_operation == lpm_pkg::OP_LOOKUP) ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN: begin
                if (!w_issue && !r_rd_pend) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_scan_idx <= '0;
            r_rd_pend  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= w_issue;
            if (w_accept) begin
                r_scan_idx <= '0;
                if (i_operation == lpm_pkg::OP_CLEAR) begin
                    r_count <= '0;
                end else if ((i_operation == lpm_pkg::OP_INSERT) && !w_full) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (w_issue) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
        end
    end

    // pending result and query address
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query      <= i_address;
            r_res_prefix <= '0;
            r_res_length <= '0;
            r_res_as     <= '0;
            case (i_operation)
                lpm_pkg::OP_INSERT: r_res_status <= w_full ? lpm_pkg::ST_FULL
                                                           : lpm_pkg::ST_OK;
                lpm_pkg::OP_LOOKUP: r_res_status <= lpm_pkg::ST_MISS;
                default:            r_res_status <= lpm_pkg::ST_OK;
            endcase
        end else if (w_hit) begin
            r_res_status <= lpm_pkg::ST_OK;
            r_res_prefix <= r_rd_data.prefix;
            r_res_length <= r_rd_data.length;
            r_res_as     <= r_rd_data.as_num;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_prefix <= r_res_prefix;
            r_out_length <= r_res_length;
            r_out_as     <= r_res_as;
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_matched_prefix = r_out_prefix;
    assign o_matched_length = r_out_length;
    assign o_matched_as     = r_out_as;

endmodule

`default_nettype wire
